// ===== sv/spq_pkg.sv =====
// package with entry, command and status types for the sorted priority queue
package spq_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 16;
    localparam int OCC_W = 5;

    // action codes of an input beat
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // one stored entry of the chain
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_entry;

    // operation broadcast to every cell
    typedef struct packed {
        logic                    enq;
        logic                    deq;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_cmd;

endpackage

// ===== sv/sorted_priority_queue.sv =====
// top level of the bounded min-first sorted priority queue
// A bounded min-first priority queue held in a row of CAPACITY compare and
// shift cells, sorted by signed key with the smallest in cell 0; equal keys
// leave in arrival order. Each input beat either enqueues a key and tag or
// dequeues the head, and yields exactly one result beat in the next cycle from
// an output register. The block takes one beat per cycle: the input is ready
// whenever the output register is empty or being taken in the same cycle, so
// only output backpressure slows it. The cycle is set by the 32-bit key
// compare in every cell and the neighbor select behind it. An enqueue into a
// full queue is dropped with status full; a dequeue on an empty queue returns
// status empty. Keys and tags of a result are zero unless it is a dequeue.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // entry_key [31:0], payload_tag [47:32]
    input  logic        i_s_tuser,   // action [0]
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // out_key [31:0], out_tag [47:32], occupancy [52:48]
    output logic [1:0]  o_m_tuser    // status [1:0]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_entry w_entry [CAPACITY];
    logic   w_le    [CAPACITY];
    t_cmd   w_cmd;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic             w_act;
    t_status          w_status;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W+OCC_W-1:0] w_count_ext;

    logic             r_out_valid;
    t_status          r_status;
    logic [KEY_W-1:0] r_key;
    logic [TAG_W-1:0] r_tag;
    logic [OCC_W-1:0] r_occ;

    // input handshake
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_act      = i_s_tuser;

    assign w_full  = w_entry[CAPACITY-1].valid;
    assign w_empty = !w_entry[0].valid;

    // command broadcast to the chain
    always_comb begin
        w_cmd.enq = w_accept && (w_act == ACT_ENQ) && !w_full;
        w_cmd.deq = w_accept && (w_act == ACT_DEQ) && !w_empty;
        w_cmd.key = i_s_tdata[31:0];
        w_cmd.tag = i_s_tdata[47:32];
    end

    // row of cells, cell 0 holds the smallest key
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_le;

        if (g == 0) begin : g_head
            assign w_left    = '0;
            assign w_left_le = 1'b1;
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_left_le = w_le[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_left    (w_left),
            .i_left_le (w_left_le),
            .i_right   (w_right),
            .o_entry   (w_entry[g]),
            .o_le      (w_le[g])
        );
    end

    // status and occupancy after this beat
    always_comb begin
        n_count = r_count;
        if (w_act == ACT_ENQ) begin
            w_status = w_full ? ST_FULL : ST_ENQ;
        end else begin
            w_status = w_empty ? ST_EMPTY : ST_DEQ;
        end
        if (w_cmd.enq) begin
            n_count = r_count + 1'b1;
        end else if (w_cmd.deq) begin
            n_count = r_count - 1'b1;
        end
    end

    assign w_count_ext = {{OCC_W{1'b0}}, n_count};

    // entry count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_occ    <= w_count_ext[OCC_W-1:0];
            if (w_cmd.deq) begin
                r_key <= w_entry[0].key;
                r_tag <= w_entry[0].tag;
            end else begin
                r_key <= '0;
                r_tag <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_occ, r_tag, r_key};
    assign o_m_tuser  = r_status;

endmodule

// ===== sv/spq_cell.sv =====
// one compare and shift cell of the sorted chain
module spq_cell
    import spq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  t_entry i_left,
    input  logic   i_left_le,
    input  t_entry i_right,
    output t_entry o_entry,
    output logic   o_le
);

    t_entry r_entry;
    t_entry n_entry;

    // stored key is at or below the new key, so the new entry goes behind it
    assign o_le = r_entry.valid && (r_entry.key <= i_cmd.key);

    // next contents: keep, take the new entry, or shift from a neighbor
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.enq) begin
            if (!o_le) begin
                if (i_left_le) begin
                    n_entry.valid = 1'b1;
                    n_entry.key   = i_cmd.key;
                    n_entry.tag   = i_cmd.tag;
                end else begin
                    n_entry = i_left;
                end
            end
        end else if (i_cmd.deq) begin
            n_entry = i_right;
        end
    end

    // valid bit under reset, key and tag need no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.key <= n_entry.key;
        r_entry.tag <= n_entry.tag;
    end

    assign o_entry = r_entry;

endmodule

// ===== tb/sv/tb_sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the sorted priority queue with stream driver and monitor
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int N_RANDOM  = 750;
    // cycles after reset during which neither side idles
    localparam int CALM_FROM = 300;
    localparam int CALM_TO   = 700;

    // one request beat as it enters the queue
    typedef struct {
        logic                    act;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_req;

    // one result beat as it leaves the queue
    typedef struct {
        t_status                 status;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic [OCC_W-1:0]        occ;
    } t_res;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [47:0] i_s_tdata  = '0;   // entry_key [31:0], payload_tag [47:32]
    logic        i_s_tuser  = 1'b0; // action [0]
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [55:0] o_m_tdata;         // out_key [31:0], out_tag [47:32], occupancy [52:48]
    logic [1:0]  o_m_tuser;         // status [1:0]

    t_req req_q[$];
    t_res due_q[$];
    int   cyc          = 0;
    int   mismatch_cnt = 0;

    // sorted contents as the queue should hold them, head in slot 0
    logic signed [KEY_W-1:0] held_key[DEPTH];
    logic [TAG_W-1:0]        held_tag[DEPTH];
    int                      held_n = 0;

    sorted_priority_queue #(
        .CAPACITY (DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // apply one request to the held contents and return the result it gives
    function automatic t_res sorted_apply(t_req r);
        t_res res;
        int   pos;
        res.status = ST_ENQ;
        res.key    = '0;
        res.tag    = '0;
        if (r.act == ACT_ENQ) begin
            if (held_n >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // new entry goes behind every key less than or equal to it
                pos = 0;
                while (pos < held_n && held_key[pos] <= r.key) pos++;
                for (int i = held_n; i > pos; i--) begin
                    held_key[i] = held_key[i-1];
                    held_tag[i] = held_tag[i-1];
                end
                held_key[pos] = r.key;
                held_tag[pos] = r.tag;
                held_n++;
            end
        end else begin
            if (held_n == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.status = ST_DEQ;
                res.key    = held_key[0];
                res.tag    = held_tag[0];
                for (int i = 1; i < held_n; i++) begin
                    held_key[i-1] = held_key[i];
                    held_tag[i-1] = held_tag[i];
                end
                held_n--;
            end
        end
        res.occ = held_n[OCC_W-1:0];
        return res;
    endfunction

    function automatic void add_req(logic act, logic signed [KEY_W-1:0] key,
                                    logic [TAG_W-1:0] tag);
        t_req r;
        r.act = act;
        r.key = key;
        r.tag = tag;
        req_q.push_back(r);
    endfunction

    // keys: mostly a narrow band for many ties, some full range, some extremes
    function automatic logic signed [KEY_W-1:0] pick_key();
        int k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                k = $urandom_range(0, 7);
                return k - 4;
            end
            5, 6, 7: return $urandom;
            default: begin
                case ($urandom_range(0, 5))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0000_0000;
                    3: return -32'sd1;
                    4: return 32'sh8000_0001;
                    default: return 32'sh7fff_fffe;
                endcase
            end
        endcase
    endfunction

    function automatic void check_field(string what, logic [KEY_W-1:0] want,
                                        logic [KEY_W-1:0] got);
        if (got !== want) begin
            if (mismatch_cnt < 10)
                $display("mismatch in %s: expected %h, got %h", what, want, got);
            mismatch_cnt++;
        end
    endfunction

    function automatic logic calm_now();
        return cyc >= CALM_FROM && cyc < CALM_TO;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) cyc <= cyc + 1;
    end

    // request driver, holds a beat until it is taken
    always @(posedge i_clk) begin
        t_req r;
        if (i_rst_n && (!i_s_tvalid || o_s_tready)) begin
            if (req_q.size() != 0 && (calm_now() || $urandom_range(0, 99) >= 16)) begin
                r = req_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {r.tag, r.key};
                i_s_tuser  <= r.act;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // result side backpressure
    always @(posedge i_clk) begin
        i_m_tready <= calm_now() || ($urandom_range(0, 99) >= 16);
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_req r;
        t_res want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                r.act = i_s_tuser;
                r.key = i_s_tdata[31:0];
                r.tag = i_s_tdata[47:32];
                due_q.push_back(sorted_apply(r));
            end
            if (o_m_tvalid && i_m_tready) begin
                if (due_q.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("result beat with none expected: tdata %h tuser %h",
                                 o_m_tdata, o_m_tuser);
                    mismatch_cnt++;
                end else begin
                    want = due_q.pop_front();
                    check_field("status", 32'(want.status), 32'(o_m_tuser));
                    check_field("out_key", want.key, o_m_tdata[31:0]);
                    check_field("out_tag", 32'(want.tag), 32'(o_m_tdata[47:32]));
                    check_field("occupancy", 32'(want.occ), 32'(o_m_tdata[52:48]));
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int n;
        int len;
        int bias;

        // dequeues on an empty queue, plain and with all-ones fields
        add_req(ACT_DEQ, '0, '0);
        add_req(ACT_DEQ, -32'sd1, 16'hffff);
        // fill to capacity with extreme keys, ties at both ends and in the middle
        add_req(ACT_ENQ, 32'sh7fff_ffff, 16'hffff);
        add_req(ACT_ENQ, 32'sh8000_0000, 16'h0001);
        add_req(ACT_ENQ, 32'sh0000_0000, 16'h0000);
        add_req(ACT_ENQ, -32'sd1, 16'h8000);
        add_req(ACT_ENQ, 32'sd5, 16'h000a);
        add_req(ACT_ENQ, 32'sd5, 16'h000b);
        add_req(ACT_ENQ, 32'sd5, 16'h000c);
        add_req(ACT_ENQ, 32'sh8000_0000, 16'h0002);
        add_req(ACT_ENQ, 32'sh7fff_ffff, 16'h0003);
        add_req(ACT_ENQ, -32'sd3, 16'h1234);
        add_req(ACT_ENQ, 32'sd7, 16'h5555);
        add_req(ACT_ENQ, 32'sd100, 16'haaaa);
        add_req(ACT_ENQ, -32'sd100, 16'h00ff);
        add_req(ACT_ENQ, 32'sd1, 16'hff00);
        add_req(ACT_ENQ, 32'sd2, 16'h0f0f);
        add_req(ACT_ENQ, 32'sd3, 16'hf0f0);
        // one more on a full queue is dropped
        add_req(ACT_ENQ, 32'sd4, 16'hbeef);
        repeat (4) add_req(ACT_DEQ, $urandom, 16'($urandom));

        // random runs that lean toward filling, draining or neither
        n = 0;
        while (n < N_RANDOM) begin
            case ($urandom_range(0, 2))
                0: bias = 85;
                1: bias = 15;
                default: bias = 50;
            endcase
            len = $urandom_range(8, 40);
            for (int j = 0; j < len && n < N_RANDOM; j++) begin
                if ($urandom_range(0, 99) < bias)
                    add_req(ACT_ENQ, pick_key(), 16'($urandom));
                else
                    add_req(ACT_DEQ, $urandom, 16'($urandom));
                n++;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (due_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hard stop in case the queue hangs
    initial begin
        #200000;
        $display("simulation failed");
        $finish;
    end

endmodule
